### rtl/core/udp_frame_manchester_tx_top_defines.svh
// Assertion macros for the UDP frame transmitter.
// The including module provides clk and rst_n.
`ifndef UDP_FRAME_MANCHESTER_TX_TOP_DEFINES_SVH
`define UDP_FRAME_MANCHESTER_TX_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define UFM_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("udp frame tx: property violated");
`define UFM_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("udp frame tx: forbidden condition seen");
`else
`define UFM_ASSERT(name, prop)
`define UFM_ASSERT_NEVER(name, cond)
`endif

`endif

### rtl/core/ufm_tx_pkg.sv
package ufm_tx_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_MAC      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_IP       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_IP         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_UDP_PORT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_UDP_PORT   = 3'd4;

  localparam logic [47:0] RST_SOURCE_MAC = 48'hE45F01000000;
  localparam logic [31:0] RST_SOURCE_IP  = 32'hC0A883B0;
  localparam logic [31:0] RST_DEST_IP    = 32'hC0A88370;
  localparam logic [15:0] RST_UDP_PORT   = 16'd1234;

  localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;
  localparam logic [31:0] IDLE_WORD  = 32'h00000AAA;
  localparam logic [7:0]  PREAMBLE   = 8'h55;
  localparam logic [7:0]  SFD        = 8'hD5;
  localparam logic [47:0] BCAST_MAC  = 48'hFFFFFFFFFFFF;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  IP_VER_IHL = 8'h45;
  localparam logic [7:0]  IP_TOS     = 8'h00;
  localparam logic [7:0]  IP_TTL     = 8'h80;
  localparam logic [7:0]  IP_PROTO   = 8'h11;
  localparam logic [15:0] IP_HDR_OVH = 16'd28;
  localparam logic [15:0] UDP_HDR_OVH = 16'd8;

  localparam int HDR_W = 6;
  localparam logic [HDR_W-1:0] HDR_LAST      = 6'd49;
  localparam logic [HDR_W-1:0] HDR_CRC_START = 6'd8;

  typedef struct packed {
    logic [47:0] source_mac;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [15:0] source_udp_port;
    logic [15:0] dest_udp_port;
  } cfg_t;

  typedef struct packed {
    logic [10:0] len;
    logic [15:0] id;
    logic [15:0] csum;
  } hdr_fields_t;

  typedef enum logic [1:0] {
    PH_HDR,
    PH_DATA,
    PH_FCS,
    PH_IDLE
  } phase_t;

  function automatic logic [31:0] manchester(input logic [7:0] b);
    logic [31:0] w;
    w = '0;
    for (int k = 0; k < 8; k++) begin
      w[4*k +: 4] = b[k] ? 4'h9 : 4'h6;
    end
    return w;
  endfunction

endpackage

### rtl/core/ufm_tx_if.sv
interface ufm_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic [10:0] payload_length;

  modport source (output valid, output payload_byte, output payload_length, input ready);
  modport sink (input valid, input payload_byte, input payload_length, output ready);
endinterface

interface ufm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] line_word;
  logic [7:0]  frame_byte;
  logic        end_of_frame;

  modport source (output valid, output line_word, output frame_byte, output end_of_frame,
                  input ready);
  modport sink (input valid, input line_word, input frame_byte, input end_of_frame,
                output ready);
endinterface

interface ufm_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [ufm_tx_pkg::CFG_IDX_W-1:0]    reg_index;
  logic [ufm_tx_pkg::CFG_DATA_W-1:0]   wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

### rtl/core/ufm_cfg_regs.sv
module ufm_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  ufm_cfg_if.sink           cfg_if,
  output ufm_tx_pkg::cfg_t  cfg_o
);

  ufm_tx_pkg::cfg_t cfg_r;

  assign cfg_if.ready = 1'b1;
  assign cfg_o        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.source_mac      <= ufm_tx_pkg::RST_SOURCE_MAC;
      cfg_r.source_ip       <= ufm_tx_pkg::RST_SOURCE_IP;
      cfg_r.dest_ip         <= ufm_tx_pkg::RST_DEST_IP;
      cfg_r.source_udp_port <= ufm_tx_pkg::RST_UDP_PORT;
      cfg_r.dest_udp_port   <= ufm_tx_pkg::RST_UDP_PORT;
    end else if (cfg_if.valid && cfg_if.ready) begin
      unique case (cfg_if.reg_index)
        ufm_tx_pkg::CFG_SOURCE_MAC:      cfg_r.source_mac      <= cfg_if.wr_data;
        ufm_tx_pkg::CFG_SOURCE_IP:       cfg_r.source_ip       <= cfg_if.wr_data[31:0];
        ufm_tx_pkg::CFG_DEST_IP:         cfg_r.dest_ip         <= cfg_if.wr_data[31:0];
        ufm_tx_pkg::CFG_SOURCE_UDP_PORT: cfg_r.source_udp_port <= cfg_if.wr_data[15:0];
        ufm_tx_pkg::CFG_DEST_UDP_PORT:   cfg_r.dest_udp_port   <= cfg_if.wr_data[15:0];
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

endmodule

### rtl/core/ufm_hdr_gen.sv
module ufm_hdr_gen (
  input  logic [ufm_tx_pkg::HDR_W-1:0] step,
  input  ufm_tx_pkg::cfg_t             cfg,
  input  ufm_tx_pkg::hdr_fields_t      fld,
  output logic [7:0]                   hdr_byte,
  output logic                         hdr_crc
);

  logic [15:0] total_len;
  logic [15:0] udp_len;

  assign udp_len   = {5'b0, fld.len} + ufm_tx_pkg::UDP_HDR_OVH;
  assign total_len = {5'b0, fld.len} + ufm_tx_pkg::IP_HDR_OVH;
  assign hdr_crc   = (step >= ufm_tx_pkg::HDR_CRC_START);

  always_comb begin
    unique case (step)
      6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6: hdr_byte = ufm_tx_pkg::PREAMBLE;
      6'd7:  hdr_byte = ufm_tx_pkg::SFD;
      6'd8:  hdr_byte = ufm_tx_pkg::BCAST_MAC[47:40];
      6'd9:  hdr_byte = ufm_tx_pkg::BCAST_MAC[39:32];
      6'd10: hdr_byte = ufm_tx_pkg::BCAST_MAC[31:24];
      6'd11: hdr_byte = ufm_tx_pkg::BCAST_MAC[23:16];
      6'd12: hdr_byte = ufm_tx_pkg::BCAST_MAC[15:8];
      6'd13: hdr_byte = ufm_tx_pkg::BCAST_MAC[7:0];
      6'd14: hdr_byte = cfg.source_mac[47:40];
      6'd15: hdr_byte = cfg.source_mac[39:32];
      6'd16: hdr_byte = cfg.source_mac[31:24];
      6'd17: hdr_byte = cfg.source_mac[23:16];
      6'd18: hdr_byte = cfg.source_mac[15:8];
      6'd19: hdr_byte = cfg.source_mac[7:0];
      6'd20: hdr_byte = ufm_tx_pkg::ETHERTYPE_IPV4[15:8];
      6'd21: hdr_byte = ufm_tx_pkg::ETHERTYPE_IPV4[7:0];
      6'd22: hdr_byte = ufm_tx_pkg::IP_VER_IHL;
      6'd23: hdr_byte = ufm_tx_pkg::IP_TOS;
      6'd24: hdr_byte = total_len[15:8];
      6'd25: hdr_byte = total_len[7:0];
      6'd26: hdr_byte = fld.id[15:8];
      6'd27: hdr_byte = fld.id[7:0];
      6'd30: hdr_byte = ufm_tx_pkg::IP_TTL;
      6'd31: hdr_byte = ufm_tx_pkg::IP_PROTO;
      6'd32: hdr_byte = fld.csum[15:8];
      6'd33: hdr_byte = fld.csum[7:0];
      6'd34: hdr_byte = cfg.source_ip[31:24];
      6'd35: hdr_byte = cfg.source_ip[23:16];
      6'd36: hdr_byte = cfg.source_ip[15:8];
      6'd37: hdr_byte = cfg.source_ip[7:0];
      6'd38: hdr_byte = cfg.dest_ip[31:24];
      6'd39: hdr_byte = cfg.dest_ip[23:16];
      6'd40: hdr_byte = cfg.dest_ip[15:8];
      6'd41: hdr_byte = cfg.dest_ip[7:0];
      6'd42: hdr_byte = cfg.source_udp_port[15:8];
      6'd43: hdr_byte = cfg.source_udp_port[7:0];
      6'd44: hdr_byte = cfg.dest_udp_port[15:8];
      6'd45: hdr_byte = cfg.dest_udp_port[7:0];
      6'd46: hdr_byte = udp_len[15:8];
      6'd47: hdr_byte = udp_len[7:0];
      // flags/fragment and UDP checksum are zero
      default: hdr_byte = 8'h00;
    endcase
  end

endmodule

### rtl/core/ufm_crc_byte.sv
module ufm_crc_byte (
  input  logic [31:0] crc_i,
  input  logic [7:0]  data_i,
  output logic [31:0] crc_o
);

  always_comb begin
    logic [31:0] c;
    c = crc_i ^ {24'b0, data_i};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ ufm_tx_pkg::CRC_POLY) : (c >> 1);
    end
    crc_o = c;
  end

endmodule

### rtl/core/udp_frame_manchester_tx_top.sv
// Broadcast Ethernet II / IPv4 / UDP frame transmitter with Manchester line words.
// in_if   : one UDP payload byte per word; payload_length is sampled on the first
//           byte of each frame (0 is taken as 1, above MAX_PAYLOAD as MAX_PAYLOAD).
// out_if  : one 32-bit Manchester line word per frame byte, with the raw byte, and
//           a closing idle word (0xAAA) flagged by end_of_frame.
// cfg_if  : register writes (MAC, IPs, UDP ports), always ready; write only while
//           no frame is in progress.
// Timing  : every word is registered in the output word register; the first word of a
//           frame is encoded once its first payload byte has been taken in.
// Throughput: payload bytes stream at one word per cycle while out_if.ready is high. The first
//           byte of a frame occupies the encoder for 51 words (50 header words plus the byte), the
//           last byte for 6 words (byte, four FCS words, idle word); in_if.ready is
//           low for the rest of those bursts. The single output word register sets
//           the one-word-per-cycle limit.
// Reset   : synchronous, active low; clears the datagram identifier, the frame state
//           and the output valid flag, presets the CRC, and restores the config defaults.
// Stall   : while out_if.ready is low the pending word holds and the encoder stops;
//           the next payload byte is still taken once the current one is finished.
`include "udp_frame_manchester_tx_top_defines.svh"

module udp_frame_manchester_tx_top #(
  parameter int MAX_PAYLOAD = 1472
) (
  input  logic       clk,
  input  logic       rst_n,
  ufm_in_if.sink     in_if,
  ufm_out_if.source  out_if,
  ufm_cfg_if.sink    cfg_if
);

  localparam logic [10:0] MAX_LEN = 11'(MAX_PAYLOAD);

  ufm_tx_pkg::cfg_t        cfg;
  ufm_tx_pkg::hdr_fields_t hdr_fld;
  ufm_tx_pkg::phase_t      phase_r, phase_nxt;

  logic                         work_vld_r;
  logic [ufm_tx_pkg::HDR_W-1:0] step_r, step_nxt;
  logic [7:0]                   byte_r;
  logic [10:0]                  len_r;
  logic [10:0]                  remain_r;
  logic [15:0]                  id_r;
  logic [31:0]                  crc_r;
  logic [31:0]                  crc_nxt;
  logic                         in_frame_r;
  logic [19:0]                  sum_r;
  logic [15:0]                  csum_r;

  logic                         out_vld_r;
  logic [31:0]                  out_word_r;
  logic [7:0]                   out_byte_r;
  logic                         out_eof_r;

  logic [7:0]  hdr_byte;
  logic        hdr_crc;
  logic [7:0]  cur_byte;
  logic        cur_crc_en;
  logic        cur_idle;
  logic        last_word;
  logic        adv;
  logic        fin;
  logic        accept;
  logic        in_frame_after;
  logic        new_frame;
  logic [10:0] len_clamped;
  logic [31:0] fcs;
  logic [15:0] total_len;
  logic [16:0] fold1;
  logic [16:0] fold2;

  ufm_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg_o  (cfg)
  );

  assign hdr_fld.len  = len_r;
  assign hdr_fld.id   = id_r;
  assign hdr_fld.csum = csum_r;

  ufm_hdr_gen u_hdr (
    .step     (step_r),
    .cfg      (cfg),
    .fld      (hdr_fld),
    .hdr_byte (hdr_byte),
    .hdr_crc  (hdr_crc)
  );

  ufm_crc_byte u_crc (
    .crc_i  (crc_r),
    .data_i (cur_byte),
    .crc_o  (crc_nxt)
  );

  assign fcs = ~crc_r;

  // Word produced by the current phase
  always_comb begin
    cur_byte   = 8'h00;
    cur_crc_en = 1'b0;
    cur_idle   = 1'b0;
    last_word  = 1'b0;
    unique case (phase_r)
      ufm_tx_pkg::PH_HDR: begin
        cur_byte   = hdr_byte;
        cur_crc_en = hdr_crc;
      end
      ufm_tx_pkg::PH_DATA: begin
        cur_byte   = byte_r;
        cur_crc_en = 1'b1;
        last_word  = (remain_r != 11'd1);
      end
      ufm_tx_pkg::PH_FCS: begin
        unique case (step_r[1:0])
          2'd0: cur_byte = fcs[7:0];
          2'd1: cur_byte = fcs[15:8];
          2'd2: cur_byte = fcs[23:16];
          2'd3: cur_byte = fcs[31:24];
        endcase
      end
      ufm_tx_pkg::PH_IDLE: begin
        cur_idle  = 1'b1;
        last_word = 1'b1;
      end
    endcase
  end

  // Next phase and step
  always_comb begin
    phase_nxt = phase_r;
    step_nxt  = step_r;
    unique case (phase_r)
      ufm_tx_pkg::PH_HDR: begin
        if (step_r == ufm_tx_pkg::HDR_LAST) begin
          phase_nxt = ufm_tx_pkg::PH_DATA;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + 6'd1;
        end
      end
      ufm_tx_pkg::PH_DATA: begin
        if (remain_r == 11'd1) begin
          phase_nxt = ufm_tx_pkg::PH_FCS;
          step_nxt  = '0;
        end
      end
      ufm_tx_pkg::PH_FCS: begin
        if (step_r[1:0] == 2'd3) begin
          phase_nxt = ufm_tx_pkg::PH_IDLE;
        end else begin
          step_nxt = step_r + 6'd1;
        end
      end
      ufm_tx_pkg::PH_IDLE: begin
        phase_nxt = phase_r;
      end
    endcase
  end

  assign adv    = work_vld_r && (!out_vld_r || out_if.ready);
  assign fin    = adv && last_word;
  assign in_if.ready = !work_vld_r || fin;
  assign accept = in_if.valid && in_if.ready;

  // The closing idle word ends the frame in the same cycle a new byte may arrive
  assign in_frame_after = (fin && (phase_r == ufm_tx_pkg::PH_IDLE)) ? 1'b0 : in_frame_r;
  assign new_frame      = accept && !in_frame_after;

  always_comb begin
    priority if (in_if.payload_length == 11'd0) begin
      len_clamped = 11'd1;
    end else if (in_if.payload_length > MAX_LEN) begin
      len_clamped = MAX_LEN;
    end else begin
      len_clamped = in_if.payload_length;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_vld_r <= 1'b0;
      phase_r    <= ufm_tx_pkg::PH_HDR;
      step_r     <= '0;
      remain_r   <= '0;
      id_r       <= '0;
      crc_r      <= ufm_tx_pkg::CRC_INIT;
      in_frame_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (accept) begin
        work_vld_r <= 1'b1;
      end else if (fin) begin
        work_vld_r <= 1'b0;
      end
      if (accept) begin
        step_r  <= '0;
        phase_r <= new_frame ? ufm_tx_pkg::PH_HDR : ufm_tx_pkg::PH_DATA;
      end else if (adv) begin
        phase_r <= phase_nxt;
        step_r  <= step_nxt;
      end
      if (new_frame) begin
        id_r       <= id_r + 16'd1;
        crc_r      <= ufm_tx_pkg::CRC_INIT;
        remain_r   <= len_clamped;
        in_frame_r <= 1'b1;
      end else if (adv) begin
        if (cur_crc_en) begin
          crc_r <= crc_nxt;
        end
        if (phase_r == ufm_tx_pkg::PH_DATA) begin
          remain_r <= remain_r - 11'd1;
        end
        if (phase_r == ufm_tx_pkg::PH_IDLE) begin
          in_frame_r <= 1'b0;
        end
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // IPv4 header checksum: sum during the first preamble word, fold during the second
  assign total_len = {5'b0, len_r} + ufm_tx_pkg::IP_HDR_OVH;
  assign fold1     = {1'b0, sum_r[15:0]} + {13'b0, sum_r[19:16]};
  assign fold2     = {1'b0, fold1[15:0]} + {16'b0, fold1[16]};

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_if.payload_byte;
    end
    if (new_frame) begin
      len_r <= len_clamped;
    end
    if (phase_r == ufm_tx_pkg::PH_HDR && step_r == 6'd0) begin
      sum_r <= 20'(16'h4500) + 20'(total_len) + 20'(id_r) + 20'(16'h8011)
             + 20'(cfg.source_ip[31:16]) + 20'(cfg.source_ip[15:0])
             + 20'(cfg.dest_ip[31:16]) + 20'(cfg.dest_ip[15:0]);
    end
    if (phase_r == ufm_tx_pkg::PH_HDR && step_r == 6'd1) begin
      csum_r <= ~fold2[15:0];
    end
    if (adv) begin
      out_word_r <= cur_idle ? ufm_tx_pkg::IDLE_WORD : ufm_tx_pkg::manchester(cur_byte);
      out_byte_r <= cur_byte;
      out_eof_r  <= cur_idle;
    end
  end

  assign out_if.valid        = out_vld_r;
  assign out_if.line_word    = out_word_r;
  assign out_if.frame_byte   = out_byte_r;
  assign out_if.end_of_frame = out_eof_r;

  `UFM_ASSERT(a_eof_is_idle, out_vld_r && out_eof_r |-> out_word_r == ufm_tx_pkg::IDLE_WORD && out_byte_r == 8'h00)
  `UFM_ASSERT_NEVER(a_idle_without_eof, out_vld_r && !out_eof_r && out_word_r == ufm_tx_pkg::IDLE_WORD)
  `UFM_ASSERT(a_id_advances, new_frame |=> id_r == $past(id_r) + 16'd1)
  `UFM_ASSERT_NEVER(a_data_underrun, work_vld_r && phase_r == ufm_tx_pkg::PH_DATA && remain_r == 11'd0)

endmodule

### tb/udp_frame_manchester_tx_top_tb.sv
`timescale 1ns / 100ps

module udp_frame_manchester_tx_top_tb;

  localparam int MAX_PAYLOAD   = 1472;
  localparam int RESET_CYCLES  = 8;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE        = 8;
  localparam int DRAIN_CYCLES  = 20;
  localparam int LIMIT         = 600_000;
  localparam int RANDOM_ITEMS  = 120;
  localparam int RANDOM_PHASES = 6;
  localparam int DIR_COUNT     = 15;

  // indexes past the last register, which the block must ignore
  localparam logic [ufm_tx_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
  localparam logic [ufm_tx_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef enum logic [1:0] {CFG_KEEP, CFG_ZEROS, CFG_ONES} cfg_plan_t;

  typedef struct packed {
    cfg_plan_t   plan;
    logic [7:0]  payload;
    logic [10:0] length;
    logic        typed;
    logic [31:0] word;
  } stim_row_t;

  typedef struct packed {
    logic [31:0] word;
    logic [7:0]  raw;
    logic        eof;
  } line_item_t;

  localparam stim_row_t DIR_ROWS [DIR_COUNT] = '{
    '{CFG_KEEP,  8'h00, 11'd1,   1'b1, 32'h66666666},  // first frame after reset
    '{CFG_KEEP,  8'hFF, 11'd1,   1'b1, 32'h99999999},
    '{CFG_KEEP,  8'h01, 11'd0,   1'b1, 32'h66666669},  // zero length acts as one
    '{CFG_KEEP,  8'h80, 11'd3,   1'b1, 32'h96666666},
    '{CFG_KEEP,  8'h7E, 11'h7FF, 1'b0, 32'h0},         // length ignored mid-frame
    '{CFG_KEEP,  8'hC3, 11'd0,   1'b0, 32'h0},
    '{CFG_ZEROS, 8'hFF, 11'd2,   1'b1, 32'h99999999},
    '{CFG_KEEP,  8'h00, 11'd5,   1'b1, 32'h66666666},
    '{CFG_ONES,  8'h00, 11'd1,   1'b1, 32'h66666666},
    '{CFG_KEEP,  8'h5A, 11'd4,   1'b0, 32'h0},
    '{CFG_KEEP,  8'hA5, 11'd0,   1'b0, 32'h0},
    '{CFG_KEEP,  8'h3C, 11'h7FF, 1'b0, 32'h0},
    '{CFG_KEEP,  8'h96, 11'd1,   1'b0, 32'h0},
    '{CFG_KEEP,  8'h69, 11'd1,   1'b0, 32'h0},
    '{CFG_KEEP,  8'hE7, 11'd1,   1'b0, 32'h0}
  };

  logic clk;
  logic rst_n;

  ufm_in_if  in_ch ();
  ufm_out_if out_ch ();
  ufm_cfg_if cfg_ch ();

  udp_frame_manchester_tx_top #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch),
    .cfg_if(cfg_ch)
  );

  // mirror of the block's registers and frame state
  logic [47:0] pred_mac   = ufm_tx_pkg::RST_SOURCE_MAC;
  logic [31:0] pred_sip   = ufm_tx_pkg::RST_SOURCE_IP;
  logic [31:0] pred_dip   = ufm_tx_pkg::RST_DEST_IP;
  logic [15:0] pred_sport = ufm_tx_pkg::RST_UDP_PORT;
  logic [15:0] pred_dport = ufm_tx_pkg::RST_UDP_PORT;
  logic [15:0] pred_id    = 16'h0000;
  logic [31:0] pred_crc   = ufm_tx_pkg::CRC_INIT;
  logic [10:0] pred_left  = 11'd0;
  logic        pred_busy  = 1'b0;

  line_item_t line_q [$];

  bit quiet         = 1'b0;
  bit long_hold_req = 1'b0;
  int errors        = 0;
  int words_seen    = 0;
  int frames_seen   = 0;
  int bytes_sent    = 0;
  int cfg_writes    = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] line_code(input logic [7:0] b);
    logic [31:0] w;
    int k;
    w = '0;
    for (k = 0; k < 8; k++) w = w | ((b[k] ? 32'h9 : 32'h6) << (4 * k));
    return w;
  endfunction

  function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    int k;
    r = c ^ {24'h0, b};
    for (k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ ufm_tx_pkg::CRC_POLY) : (r >> 1);
    return r;
  endfunction

  function automatic void expect_byte(input logic [7:0] b, input logic into_crc);
    if (into_crc) pred_crc = crc_step(pred_crc, b);
    line_q.push_back('{line_code(b), b, 1'b0});
  endfunction

  function automatic void expect_pair(input logic [15:0] v);
    expect_byte(v[15:8], 1'b1);
    expect_byte(v[7:0], 1'b1);
  endfunction

  // Queue the words one payload byte causes; return the slot of its own word.
  function automatic int predict_byte(input logic [7:0] b, input logic [10:0] len);
    logic [10:0] n;
    logic [15:0] udp_len;
    logic [15:0] total;
    logic [31:0] sum;
    logic [31:0] fcs;
    int k;
    int slot;
    if (!pred_busy) begin
      n = len;
      if (n == 11'd0) n = 11'd1;
      if (n > 11'(MAX_PAYLOAD)) n = 11'(MAX_PAYLOAD);
      pred_id  = pred_id + 16'd1;
      pred_crc = ufm_tx_pkg::CRC_INIT;
      udp_len  = {5'b0, n} + ufm_tx_pkg::UDP_HDR_OVH;
      total    = {5'b0, n} + ufm_tx_pkg::IP_HDR_OVH;
      sum = {16'h0, ufm_tx_pkg::IP_VER_IHL, ufm_tx_pkg::IP_TOS} + {16'h0, total}
          + {16'h0, pred_id} + {16'h0, ufm_tx_pkg::IP_TTL, ufm_tx_pkg::IP_PROTO}
          + {16'h0, pred_sip[31:16]} + {16'h0, pred_sip[15:0]}
          + {16'h0, pred_dip[31:16]} + {16'h0, pred_dip[15:0]};
      sum = {16'h0, sum[15:0]} + {16'h0, sum[31:16]};
      sum = {16'h0, sum[15:0]} + {16'h0, sum[31:16]};
      for (k = 0; k < 7; k++) expect_byte(ufm_tx_pkg::PREAMBLE, 1'b0);
      expect_byte(ufm_tx_pkg::SFD, 1'b0);
      for (k = 0; k < 6; k++) expect_byte(ufm_tx_pkg::BCAST_MAC[47 - 8 * k -: 8], 1'b1);
      for (k = 0; k < 6; k++) expect_byte(pred_mac[47 - 8 * k -: 8], 1'b1);
      expect_pair(ufm_tx_pkg::ETHERTYPE_IPV4);
      expect_pair({ufm_tx_pkg::IP_VER_IHL, ufm_tx_pkg::IP_TOS});
      expect_pair(total);
      expect_pair(pred_id);
      expect_pair(16'h0000);
      expect_pair({ufm_tx_pkg::IP_TTL, ufm_tx_pkg::IP_PROTO});
      expect_pair(~sum[15:0]);
      expect_pair(pred_sip[31:16]);
      expect_pair(pred_sip[15:0]);
      expect_pair(pred_dip[31:16]);
      expect_pair(pred_dip[15:0]);
      expect_pair(pred_sport);
      expect_pair(pred_dport);
      expect_pair(udp_len);
      expect_pair(16'h0000);
      pred_left = n;
      pred_busy = 1'b1;
    end
    slot = line_q.size();
    expect_byte(b, 1'b1);
    pred_left = pred_left - 11'd1;
    if (pred_left == 11'd0) begin
      fcs = ~pred_crc;
      for (k = 0; k < 4; k++) expect_byte(fcs[8 * k +: 8], 1'b0);
      line_q.push_back('{ufm_tx_pkg::IDLE_WORD, 8'h00, 1'b1});
      pred_busy = 1'b0;
    end
    return slot;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s at word %0d: got %h want %h", what, words_seen, got, want);
    errors++;
  endtask

  // Sender side: caller stands at a falling edge; returns at a falling edge.
  task automatic push_byte(input logic [7:0] b, input logic [10:0] len,
                           input logic typed, input logic [31:0] word);
    int gap;
    int slot;
    line_item_t fix;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.payload_byte   <= b;
    in_ch.payload_length <= len;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    slot = predict_byte(b, len);
    if (typed) begin
      fix = line_q[slot];
      fix.word = word;
      line_q[slot] = fix;
    end
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [10:0] len, output int count);
    int k;
    count = (len == 11'd0) ? 1 : ((len > 11'(MAX_PAYLOAD)) ? MAX_PAYLOAD : int'(len));
    push_byte(8'($urandom_range(0, 255)), len, 1'b0, 32'h0);
    for (k = 1; k < count; k++) begin
      push_byte(8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)), 1'b0, 32'h0);
    end
  endtask

  // Drop valid, wait out every queued word, then let the block go quiet.
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (line_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [ufm_tx_pkg::CFG_IDX_W-1:0] idx,
                           input logic [47:0] val);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wr_data   <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      ufm_tx_pkg::CFG_SOURCE_MAC:      pred_mac   = val;
      ufm_tx_pkg::CFG_SOURCE_IP:       pred_sip   = val[31:0];
      ufm_tx_pkg::CFG_DEST_IP:         pred_dip   = val[31:0];
      ufm_tx_pkg::CFG_SOURCE_UDP_PORT: pred_sport = val[15:0];
      ufm_tx_pkg::CFG_DEST_UDP_PORT:   pred_dport = val[15:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_pattern(input logic [47:0] val, input logic [47:0] spare_val);
    write_reg(ufm_tx_pkg::CFG_SOURCE_MAC, val);
    write_reg(ufm_tx_pkg::CFG_SOURCE_IP, val);
    write_reg(ufm_tx_pkg::CFG_DEST_IP, val);
    write_reg(ufm_tx_pkg::CFG_SOURCE_UDP_PORT, val);
    write_reg(ufm_tx_pkg::CFG_DEST_UDP_PORT, val);
    write_reg(CFG_SPARE_LO, spare_val);
    write_reg(CFG_SPARE_HI, spare_val);
  endtask

  function automatic logic [47:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 48'h0;
      1:       return '1;
      default: return {16'($urandom), 32'($urandom)};
    endcase
  endfunction

  task automatic shuffle_config();
    if ($urandom_range(0, 3) != 0) write_reg(ufm_tx_pkg::CFG_SOURCE_MAC, pick_value());
    if ($urandom_range(0, 3) != 0) write_reg(ufm_tx_pkg::CFG_SOURCE_IP, pick_value());
    if ($urandom_range(0, 3) != 0) write_reg(ufm_tx_pkg::CFG_DEST_IP, pick_value());
    if ($urandom_range(0, 3) != 0) write_reg(ufm_tx_pkg::CFG_SOURCE_UDP_PORT, pick_value());
    if ($urandom_range(0, 3) != 0) write_reg(ufm_tx_pkg::CFG_DEST_UDP_PORT, pick_value());
    if ($urandom_range(0, 3) == 0) begin
      write_reg(3'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), pick_value());
    end
  endtask

  // receiver: random stalls, and one long hold on request
  initial begin : sink_side
    int n;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        for (n = 1; n < LONG_HOLD; n++) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        n = $urandom_range(1, 16);
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : line_check
    line_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (line_q.size() == 0) begin
        report("unexpected word", out_ch.line_word, 32'h0);
      end else begin
        want = line_q.pop_front();
        if (out_ch.line_word !== want.word) report("line_word", out_ch.line_word, want.word);
        if (out_ch.frame_byte !== want.raw) begin
          report("frame_byte", {24'h0, out_ch.frame_byte}, {24'h0, want.raw});
        end
        if (out_ch.end_of_frame !== want.eof) begin
          report("end_of_frame", {31'h0, out_ch.end_of_frame}, {31'h0, want.eof});
        end
        if (want.eof) frames_seen++;
      end
      words_seen++;
    end
  end

  initial begin : watchdog
    repeat (LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int i;
    int ph;
    int sent;
    int count;
    int target;
    logic [10:0] len;
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.payload_byte   = 8'h00;
    in_ch.payload_length = 11'd0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.reg_index     = ufm_tx_pkg::CFG_SOURCE_MAC;
    cfg_ch.wr_data       = 48'h0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (i = 0; i < DIR_COUNT; i++) begin
      if (DIR_ROWS[i].plan != CFG_KEEP) begin
        settle_block();
        if (DIR_ROWS[i].plan == CFG_ZEROS) load_pattern(48'h0, '1);
        else load_pattern('1, 48'h0);
      end
      push_byte(DIR_ROWS[i].payload, DIR_ROWS[i].length, DIR_ROWS[i].typed, DIR_ROWS[i].word);
    end

    target = RANDOM_ITEMS / RANDOM_PHASES;
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle_block();
      shuffle_config();
      if (ph == RANDOM_PHASES - 1) quiet = 1'b1;
      sent = 0;
      // hold the receiver off while a long frame keeps arriving
      if (ph == 1) begin
        long_hold_req = 1'b1;
        send_frame(11'd30, count);
        sent += count;
      end
      while (sent < target) begin
        case ($urandom_range(0, 15))
          0:       len = 11'd0;
          1, 2:    len = 11'($urandom_range(9, 40));
          default: len = 11'($urandom_range(1, 8));
        endcase
        send_frame(len, count);
        sent += count;
      end
    end

    settle_block();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("covered %0d frames, %0d line words, %0d payload bytes, %0d register writes",
             frames_seen, words_seen, bytes_sent, cfg_writes);
    $display("config extremes, clamped lengths, a %0d-cycle receiver hold, idle gaps both sides",
             LONG_HOLD);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
